// File: design/ptds_pkg.sv
// Shared types and constants for the tone divider search unit.
package ptds_pkg;

  localparam int unsigned NUM_W   = 32;  // width of 16 * system clock
  localparam int unsigned DEN_W   = 16;  // width of the frequency
  localparam int unsigned CLK_W   = 28;  // width of the clock register
  localparam int unsigned DIV_W   = 12;  // width of the 8.4 divider
  localparam int unsigned CNT_W   = 16;  // width of the wrap count
  localparam int unsigned PROD_W  = 64;

  // Reciprocals for exact division of any 32-bit value by 5 and by 3.
  localparam logic [NUM_W-1:0] RECIP_5 = 32'hCCCC_CCCD;  // shift 34
  localparam logic [NUM_W-1:0] RECIP_3 = 32'hAAAA_AAAB;  // shift 33

  localparam logic [NUM_W-1:0] Q_MIN_5   = 32'd80;    // 16 * 5
  localparam logic [NUM_W-1:0] Q_MIN_3   = 32'd48;    // 16 * 3
  localparam logic [NUM_W-1:0] Q_MIN_2   = 32'd32;    // 16 * 2
  localparam logic [NUM_W-1:0] DIV_LOW   = 32'd16;
  localparam logic [NUM_W-1:0] DIV_HIGH  = 32'd4096;  // 256 * 16

  localparam logic [CLK_W-1:0] SYS_CLOCK_RESET = 28'd125000000;

  typedef enum logic {
    FAC_5,
    FAC_3
  } fac_sel_t;

endpackage

// File: design/ptds_divider.sv
// Restoring divider, one quotient bit per cycle.
module ptds_divider
  import ptds_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int unsigned STEP_W = $clog2(NUM_W);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [DEN_W-1:0]  rem_r;
  logic [DEN_W-1:0]  den_r;
  logic [NUM_W-1:0]  acc_r;

  logic [DEN_W:0]    shifted;
  logic              fits;
  logic [DEN_W:0]    diff;

  assign shifted = {rem_r, acc_r[NUM_W-1]};
  assign fits    = shifted >= {1'b0, den_r};
  assign diff    = shifted - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + STEP_W'(1);
        if (step_r == STEP_W'(NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      acc_r <= num_i;
      den_r <= den_i;
      rem_r <= '0;
    end else if (busy_r) begin
      // remainder stays below the divisor, so the low bits carry it
      rem_r <= fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      acc_r <= {acc_r[NUM_W-2:0], fits};
    end
  end

  assign done_o = done_r;
  assign quo_o  = acc_r;

endmodule

// File: design/ptds_recip_mul.sv
// Shared reciprocal multiplier: registered quotient of q by 5 or by 3.
module ptds_recip_mul
  import ptds_pkg::*;
(
  input  logic             clk,
  input  fac_sel_t         sel_i,
  input  logic [NUM_W-1:0] q_i,
  output logic [NUM_W-1:0] quo_o
);

  logic [PROD_W-1:0] prod_r;
  fac_sel_t          sel_r;
  logic [NUM_W-1:0]  recip;

  always_comb begin
    unique case (sel_i)
      FAC_5:   recip = RECIP_5;
      FAC_3:   recip = RECIP_3;
      default: recip = RECIP_5;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(q_i) * PROD_W'(recip);
    sel_r  <= sel_i;
  end

  always_comb begin
    unique case (sel_r)
      FAC_5:   quo_o = {2'b00, prod_r[PROD_W-1:34]};
      FAC_3:   quo_o = {1'b0, prod_r[PROD_W-1:33]};
      default: quo_o = {2'b00, prod_r[PROD_W-1:34]};
    endcase
  end

endmodule

// File: design/pwm_tone_divider_search_unit.sv
// Top level: tone frequency to PWM 8.4 divider and wrap count search.
//
//   channel | ports                                   | role
//   --------+-----------------------------------------+--------------------------
//   in      | in_valid, in_ready, in_freq_hz          | tone frequency request
//   out     | out_valid, out_ready, out_divider_fixed,| divider, wrap, usable flag
//           | out_wrap_count, out_valid_res           |
//   cfg     | cfg_wr_en, cfg_wr_data                  | system clock in hertz
//
// A request passes through the bit-serial divider and then through factor steps
// on the shared reciprocal multiplier, each step a multiply state and a check
// state; factors of 3 and 2 are tried only after a factor of 5 is refused.
// A zero frequency skips all of it and goes straight to the done state.
// Reset (rst_n low, synchronous) empties the block and loads 125000000 hertz.
// in_ready is high only while the sequencer is idle; a finished result waits
// in the output register, which may still be full while the next request runs.
module pwm_tone_divider_search_unit
  import ptds_pkg::*;
#(
  parameter int unsigned WRAP_LIMIT = 65534
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [DEN_W-1:0] in_freq_hz,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [DIV_W-1:0] out_divider_fixed,
  output logic [CNT_W-1:0] out_wrap_count,
  output logic             out_valid_res,
  input  logic             cfg_wr_en,
  input  logic [CLK_W-1:0] cfg_wr_data
);

  localparam int unsigned CM_W = CNT_W + 3;  // room for count times five
  localparam logic [CM_W-1:0] LIMIT = CM_W'(WRAP_LIMIT);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_MUL,
    S_CHK,
    S_DONE
  } state_t;

  state_t           state_r, state_nxt;
  fac_sel_t         sel_r, sel_nxt;
  logic [NUM_W-1:0] q_r, q_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CLK_W-1:0] sys_clock_r;

  logic             out_valid_r, out_valid_nxt;
  logic [DIV_W-1:0] out_div_r, out_div_nxt;
  logic [CNT_W-1:0] out_wrap_r, out_wrap_nxt;
  logic             out_res_r, out_res_nxt;

  logic             accept;
  logic             div_start;
  logic             div_done;
  logic [NUM_W-1:0] div_quo;
  logic [NUM_W-1:0] mul_quo;

  logic [NUM_W+1:0] back_mul;   // quotient times the tried factor
  logic             exact;
  logic [CM_W-1:0]  cnt_x5, cnt_x3, cnt_x2;
  logic             q_usable;

  assign accept    = in_valid && in_ready;
  assign div_start = accept && (in_freq_hz != '0);

  ptds_divider u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (div_start),
    .num_i   ({sys_clock_r, 4'b0000}),
    .den_i   (in_freq_hz),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  ptds_recip_mul u_mul (
    .clk   (clk),
    .sel_i (sel_r),
    .q_i   (q_r),
    .quo_o (mul_quo)
  );

  // The quotient is exact when multiplying it back gives q again.
  always_comb begin
    unique case (sel_r)
      FAC_5:   back_mul = {mul_quo, 2'b00} + {2'b00, mul_quo};
      FAC_3:   back_mul = {1'b0, mul_quo, 1'b0} + {2'b00, mul_quo};
      default: back_mul = {mul_quo, 2'b00} + {2'b00, mul_quo};
    endcase
  end

  assign exact    = back_mul == {2'b00, q_r};
  assign cnt_x5   = {1'b0, cnt_r, 2'b00} + CM_W'(cnt_r);
  assign cnt_x3   = {2'b00, cnt_r, 1'b0} + CM_W'(cnt_r);
  assign cnt_x2   = {2'b00, cnt_r, 1'b0};
  assign q_usable = (q_r >= DIV_LOW) && (q_r < DIV_HIGH);

  // Hold the system clock; the user must write it only while no request is in flight, the block does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sys_clock_r <= SYS_CLOCK_RESET;
    end else if (cfg_wr_en) begin
      sys_clock_r <= cfg_wr_data;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    sel_nxt       = sel_r;
    q_nxt         = q_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_div_nxt   = out_div_r;
    out_wrap_nxt  = out_wrap_r;
    out_res_nxt   = out_res_r;

    // Drop the pending result once it is taken.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cnt_nxt = CNT_W'(1);
          sel_nxt = FAC_5;
          if (in_freq_hz == '0) begin
            q_nxt     = '0;   // reports as unusable
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          q_nxt     = div_quo;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        // product settles in the multiplier register
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (sel_r == FAC_5) begin
          if ((q_r >= Q_MIN_5) && exact && (cnt_x5 <= LIMIT)) begin
            q_nxt   = mul_quo;
            cnt_nxt = cnt_x5[CNT_W-1:0];
          end else begin
            sel_nxt = FAC_3;
          end
          state_nxt = S_MUL;
        end else begin
          sel_nxt = FAC_5;
          priority if ((q_r >= Q_MIN_3) && exact && (cnt_x3 <= LIMIT)) begin
            q_nxt     = mul_quo;
            cnt_nxt   = cnt_x3[CNT_W-1:0];
            state_nxt = S_MUL;
          end else if ((q_r >= Q_MIN_2) && (cnt_x2 <= LIMIT)) begin
            q_nxt     = {1'b0, q_r[NUM_W-1:1]};
            cnt_nxt   = cnt_x2[CNT_W-1:0];
            state_nxt = S_MUL;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        // Advance only when the output register is free this cycle.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = q_usable;
          out_div_nxt   = q_usable ? q_r[DIV_W-1:0] : '0;
          out_wrap_nxt  = q_usable ? cnt_r : '0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sel_r       <= FAC_5;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r        <= q_nxt;
    cnt_r      <= cnt_nxt;
    out_div_r  <= out_div_nxt;
    out_wrap_r <= out_wrap_nxt;
    out_res_r  <= out_res_nxt;
  end

  assign in_ready          = state_r == S_IDLE;
  assign out_valid         = out_valid_r;
  assign out_divider_fixed = out_div_r;
  assign out_wrap_count    = out_wrap_r;
  assign out_valid_res     = out_res_r;

endmodule
